// ----- rtl/row_area_average_resampler_macros.svh -----
// Assertion helpers shared by the checker.
`ifndef ROW_AREA_AVERAGE_RESAMPLER_MACROS_SVH
`define ROW_AREA_AVERAGE_RESAMPLER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define RAAR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("row resampler check failed");

// Next-cycle implication, off while reset is high.
`define RAAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("row resampler check failed");

`endif

// ----- rtl/raar_pkg.sv -----
`default_nettype none
package raar_pkg;
   localparam int WIDTH_W     = 13;
   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_UPSCALE = 64;
   localparam int PIXEL_W     = 32;
   localparam int CHAN_W      = 8;
   localparam int SUM_W       = 20;
   localparam int PROD_W      = 2 * WIDTH_W - 1;
   localparam int REM_W       = WIDTH_W + 1;
   localparam int DIV_CNT_W   = $clog2(PROD_W);
   localparam int LANES       = 3;
   localparam int LANE_B      = 0;
   localparam int LANE_G      = 1;
   localparam int LANE_R      = 2;
   localparam int RESULT_CAP  = 64;
   localparam int RUN_CNT_W   = $clog2(RESULT_CAP + 1);
   localparam int RATIO_W     = WIDTH_W + $clog2(MAX_UPSCALE) + 1;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_WIDTH = 2'd0,
      CSR_DST_WIDTH = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic take;
      logic mul;
      logic span_start;
      logic check;
      logic avg_start;
      logic avg_finish;
      logic push;
      logic push_end;
      logic advance;
   } dp_cmd_type;

   typedef struct packed {
      logic skip;
      logic single;
      logic loop_ok;
      logic emit;
      logic div_done;
      logic rsp_free;
      logic pend_valid;
   } dp_status_type;
endpackage
`default_nettype wire

// ----- rtl/raar_intf.sv -----
`default_nettype none
interface raar_req_intf;
   import raar_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PIXEL_W-1:0]   pixel_in;
   modport source (output valid, output pixel_in, input ready);
   modport sink (input valid, input pixel_in, output ready);
endinterface

interface raar_rsp_intf;
   import raar_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PIXEL_W-1:0]   pixel_out;
   logic                 row_last;
   logic                 run_last;
   logic                 ratio_error;
   modport source (output valid, output pixel_out, output row_last, output run_last,
                   output ratio_error, input ready);
   modport sink (input valid, input pixel_out, input row_last, input run_last,
                 input ratio_error, output ready);
endinterface
`default_nettype wire

// ----- rtl/row_area_average_resampler.sv -----
// Row resampler for 32-bit BGRA pixels: each request carries one source pixel of a row of
// src_width pixels, and the block returns the dst_width area-averaged output pixels of that
// row (blue, green, red averaged with truncation, alpha 0xFF), each on the source pixel that
// closes its span. Equal widths pass pixels through with alpha kept; a ratio above 64x
// gives one flagged zero result per pixel. A pixel is worked on alone: a pixel that closes
// no span takes one division for the next span boundary, and each output pixel it yields
// adds one division for the channel averages and one for the next span boundary, plus
// control steps, all on the shared 25-step restoring divider. Passthrough and flagged
// pixels bypass the divider. A stalled result channel holds the block. Writing either
// width restarts the row.
`default_nettype none
module row_area_average_resampler (
   input  logic                             clock,
   input  logic                             reset,
   raar_req_intf.sink                       req_bus,
   raar_rsp_intf.source                     rsp_bus,
   input  logic                             csr_we,
   input  logic [raar_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [raar_pkg::WIDTH_W-1:0]     csr_wdata
);
   import raar_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   raar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   assign req_bus.ready = req_ready;

   raar_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .pixel_in    (req_bus.pixel_in),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .pixel_out   (rsp_bus.pixel_out),
      .row_last    (rsp_bus.row_last),
      .run_last    (rsp_bus.run_last),
      .ratio_error (rsp_bus.ratio_error)
   );
endmodule
`default_nettype wire

// ----- rtl/raar_div.sv -----
`default_nettype none
module raar_div (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                start,
   input  logic [raar_pkg::LANES-1:0][raar_pkg::PROD_W-1:0]    num,
   input  logic [raar_pkg::WIDTH_W-1:0]                        den,
   output logic                                                done,
   output logic [raar_pkg::LANES-1:0][raar_pkg::PROD_W-1:0]    quot
);
   import raar_pkg::*;

   logic [LANES-1:0][PROD_W-1:0] quo_ff, quo_in;
   logic [LANES-1:0][REM_W-2:0]  rem_ff, rem_in;
   logic [LANES-1:0][REM_W-1:0]  shifted, diff;
   logic [WIDTH_W-1:0]           den_ff, den_in;
   logic [DIV_CNT_W-1:0]         cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         shifted[i] = {rem_ff[i], quo_ff[i][PROD_W-1]};
         diff[i]    = shifted[i] - {1'b0, den_ff};
         if (busy_ff) begin
            if (shifted[i] >= {1'b0, den_ff}) begin
               rem_in[i] = diff[i][REM_W-2:0];
               quo_in[i] = {quo_ff[i][PROD_W-2:0], 1'b1};
            end else begin
               rem_in[i] = shifted[i][REM_W-2:0];
               quo_in[i] = {quo_ff[i][PROD_W-2:0], 1'b0};
            end
         end
      end
      if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = DIV_CNT_W'(PROD_W - 1);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule
`default_nettype wire

// ----- rtl/raar_dp.sv -----
`default_nettype none
module raar_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  raar_pkg::dp_cmd_type             cmd,
   output raar_pkg::dp_status_type          status,
   input  logic                             csr_we,
   input  logic [raar_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [raar_pkg::WIDTH_W-1:0]     csr_wdata,
   input  logic [raar_pkg::PIXEL_W-1:0]     pixel_in,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [raar_pkg::PIXEL_W-1:0]     pixel_out,
   output logic                             row_last,
   output logic                             run_last,
   output logic                             ratio_error
);
   import raar_pkg::*;

   logic [WIDTH_W-1:0]           src_ff, src_in, dst_ff, dst_in, s_eff, d_eff;
   logic [WIDTH_W-1:0]           pos_ff, pos_in, out_idx_ff, out_idx_in, lo_ff, lo_in;
   logic [WIDTH_W-1:0]           q1_ff, q1_in, n_ff, n_in, pos_eff, q1, n_val;
   logic [LANES-1:0][SUM_W-1:0]  sum_ff, sum_in, sum_base;
   logic [PROD_W-1:0]            prod_ff, prod_in;
   logic [RUN_CNT_W-1:0]         k_ff, k_in;
   logic                         is_last_ff, is_last_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [PIXEL_W-1:0]           pend_px_ff, pend_px_in;
   logic                         pend_row_last_ff, pend_row_last_in;
   logic                         pend_err_ff, pend_err_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]           rsp_px_ff, rsp_px_in;
   logic                         rsp_row_last_ff, rsp_row_last_in;
   logic                         rsp_run_last_ff, rsp_run_last_in;
   logic                         rsp_err_ff, rsp_err_in;
   logic                         skip, ratio_err, restart_need, take_last, restart_cfg;
   logic [WIDTH_W:0]             lo_inc, hi_raw, hi;
   logic                         div_start, div_done;
   logic [LANES-1:0][PROD_W-1:0] div_num, div_quot;
   logic [WIDTH_W-1:0]           div_den;

   assign s_eff = (src_ff > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : src_ff;
   assign d_eff = (dst_ff > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : dst_ff;
   assign skip  = (s_eff == '0) || (d_eff == '0);
   assign ratio_err = RATIO_W'(d_eff) > (RATIO_W'(s_eff) * RATIO_W'(MAX_UPSCALE));
   assign restart_need = (pos_ff >= s_eff) || (out_idx_ff >= d_eff);
   assign pos_eff   = restart_need ? '0 : pos_ff;
   assign take_last = ({1'b0, pos_eff} + 1'b1) == {1'b0, s_eff};
   assign sum_base  = restart_need ? '0 : sum_ff;

   assign q1     = div_quot[LANE_B][WIDTH_W-1:0];
   assign lo_inc = {1'b0, lo_ff} + 1'b1;
   assign hi_raw = ({1'b0, q1} > lo_inc) ? {1'b0, q1} : lo_inc;
   assign hi     = (hi_raw > {1'b0, s_eff}) ? {1'b0, s_eff} : hi_raw;
   assign n_val  = (hi[WIDTH_W-1:0] == lo_ff) ? WIDTH_W'(1) : hi[WIDTH_W-1:0] - lo_ff;

   assign status.skip       = skip;
   assign status.single     = ratio_err || (s_eff == d_eff);
   assign status.loop_ok    = (out_idx_ff < d_eff) && (k_ff < RUN_CNT_W'(RESULT_CAP));
   assign status.emit       = hi == ({1'b0, pos_ff} + 1'b1);
   assign status.div_done   = div_done;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign status.pend_valid = pend_valid_ff;

   always_comb begin
      div_start = cmd.span_start || cmd.avg_start;
      div_num   = '0;
      div_den   = n_ff;
      if (cmd.span_start) begin
         div_num[LANE_B] = prod_ff;
         div_den         = d_eff;
      end else begin
         for (int i = 0; i < LANES; i++) begin
            div_num[i] = PROD_W'(sum_ff[i]);
         end
      end
   end

   raar_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      src_in           = src_ff;
      dst_in           = dst_ff;
      pos_in           = pos_ff;
      out_idx_in       = out_idx_ff;
      lo_in            = lo_ff;
      q1_in            = q1_ff;
      n_in             = n_ff;
      sum_in           = sum_ff;
      prod_in          = prod_ff;
      k_in             = k_ff;
      is_last_in       = is_last_ff;
      pend_valid_in    = pend_valid_ff;
      pend_px_in       = pend_px_ff;
      pend_row_last_in = pend_row_last_ff;
      pend_err_in      = pend_err_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_px_in        = rsp_px_ff;
      rsp_row_last_in  = rsp_row_last_ff;
      rsp_run_last_in  = rsp_run_last_ff;
      rsp_err_in       = rsp_err_ff;
      restart_cfg      = 1'b0;

      if (cmd.take && !skip) begin
         if (restart_need) begin
            out_idx_in = '0;
            lo_in      = '0;
         end
         pos_in     = pos_eff;
         is_last_in = take_last;
         sum_in     = sum_base;
         if (status.single) begin
            pend_valid_in    = 1'b1;
            pend_px_in       = ratio_err ? '0 : pixel_in;
            pend_row_last_in = take_last;
            pend_err_in      = ratio_err;
         end else begin
            for (int i = 0; i < LANES; i++) begin
               sum_in[i] = sum_base[i] + SUM_W'(pixel_in[i*CHAN_W +: CHAN_W]);
            end
         end
      end

      if (cmd.mul) begin
         prod_in = (PROD_W'(out_idx_ff) + PROD_W'(1)) * PROD_W'(s_eff);
      end

      if (cmd.check) begin
         q1_in = q1;
         n_in  = n_val;
      end

      if (cmd.avg_finish) begin
         pend_valid_in    = 1'b1;
         pend_px_in       = {ALPHA_OPAQUE, div_quot[LANE_R][CHAN_W-1:0],
                             div_quot[LANE_G][CHAN_W-1:0], div_quot[LANE_B][CHAN_W-1:0]};
         pend_row_last_in = ({1'b0, out_idx_ff} + 1'b1) == {1'b0, d_eff};
         pend_err_in      = 1'b0;
         out_idx_in       = out_idx_ff + 1'b1;
         lo_in            = q1_ff;
         k_in             = k_ff + 1'b1;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.push) begin
         rsp_valid_in    = 1'b1;
         rsp_px_in       = pend_px_ff;
         rsp_row_last_in = pend_row_last_ff;
         rsp_run_last_in = cmd.push_end;
         rsp_err_in      = pend_err_ff;
         pend_valid_in   = 1'b0;
         if (cmd.push_end) begin
            sum_in = '0;
         end
      end

      if (cmd.advance) begin
         k_in = '0;
         if (is_last_ff) begin
            pos_in     = '0;
            out_idx_in = '0;
            lo_in      = '0;
            sum_in     = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH: begin
               src_in      = csr_wdata;
               restart_cfg = 1'b1;
            end
            CSR_DST_WIDTH: begin
               dst_in      = csr_wdata;
               restart_cfg = 1'b1;
            end
            default: begin
               restart_cfg = 1'b0;
            end
         endcase
      end
      if (restart_cfg) begin
         pos_in     = '0;
         out_idx_in = '0;
         lo_in      = '0;
         sum_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff        <= WIDTH_W'(1);
         dst_ff        <= WIDTH_W'(1);
         pos_ff        <= '0;
         out_idx_ff    <= '0;
         lo_ff         <= '0;
         sum_ff        <= '0;
         k_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         src_ff        <= src_in;
         dst_ff        <= dst_in;
         pos_ff        <= pos_in;
         out_idx_ff    <= out_idx_in;
         lo_ff         <= lo_in;
         sum_ff        <= sum_in;
         k_ff          <= k_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q1_ff            <= q1_in;
      n_ff             <= n_in;
      prod_ff          <= prod_in;
      is_last_ff       <= is_last_in;
      pend_px_ff       <= pend_px_in;
      pend_row_last_ff <= pend_row_last_in;
      pend_err_ff      <= pend_err_in;
      rsp_px_ff        <= rsp_px_in;
      rsp_row_last_ff  <= rsp_row_last_in;
      rsp_run_last_ff  <= rsp_run_last_in;
      rsp_err_ff       <= rsp_err_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign pixel_out   = rsp_px_ff;
   assign row_last    = rsp_row_last_ff;
   assign run_last    = rsp_run_last_ff;
   assign ratio_error = rsp_err_ff;
endmodule
`default_nettype wire

// ----- rtl/raar_ctrl.sv -----
`default_nettype none
module raar_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  raar_pkg::dp_status_type status,
   output raar_pkg::dp_cmd_type    cmd,
   output logic                    req_ready
);
   import raar_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE       = 10'b0000000001,
      ST_MUL        = 10'b0000000010,
      ST_SPAN_START = 10'b0000000100,
      ST_SPAN_WAIT  = 10'b0000001000,
      ST_CHECK      = 10'b0000010000,
      ST_PUSH_MID   = 10'b0000100000,
      ST_AVG_START  = 10'b0001000000,
      ST_AVG_WAIT   = 10'b0010000000,
      ST_PUSH_END   = 10'b0100000000,
      ST_ADVANCE    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = state_ff == ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.skip) begin
                  state_in = ST_IDLE;
               end else if (status.single) begin
                  state_in = ST_PUSH_END;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (status.loop_ok) begin
               cmd.mul  = 1'b1;
               state_in = ST_SPAN_START;
            end else begin
               state_in = ST_PUSH_END;
            end
         end
         ST_SPAN_START: begin
            cmd.span_start = 1'b1;
            state_in       = ST_SPAN_WAIT;
         end
         ST_SPAN_WAIT: begin
            if (status.div_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (!status.emit) begin
               state_in = ST_PUSH_END;
            end else if (status.pend_valid) begin
               state_in = ST_PUSH_MID;
            end else begin
               state_in = ST_AVG_START;
            end
         end
         ST_PUSH_MID: begin
            if (status.rsp_free) begin
               cmd.push = 1'b1;
               state_in = ST_AVG_START;
            end
         end
         ST_AVG_START: begin
            cmd.avg_start = 1'b1;
            state_in      = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (status.div_done) begin
               cmd.avg_finish = 1'b1;
               state_in       = ST_MUL;
            end
         end
         ST_PUSH_END: begin
            if (!status.pend_valid) begin
               state_in = ST_ADVANCE;
            end else if (status.rsp_free) begin
               cmd.push     = 1'b1;
               cmd.push_end = 1'b1;
               state_in     = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/raar_checker.sv -----
`default_nettype none
`include "row_area_average_resampler_macros.svh"
module raar_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [raar_pkg::PIXEL_W-1:0] pixel_out,
   input logic                         run_last,
   input logic                         ratio_error
);
   import raar_pkg::*;

   logic err_shape;
   logic pass_px;

   assign err_shape = (pixel_out == '0) && run_last;
   assign pass_px   = rsp_valid && !ratio_error &&
                      (pixel_out[PIXEL_W-1 -: CHAN_W] != ALPHA_OPAQUE);

   `RAAR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `RAAR_ASSERT_IMPLY(a_err_result, clock, reset, rsp_valid && ratio_error, err_shape)
   `RAAR_ASSERT_IMPLY(a_pass_single, clock, reset, pass_px, run_last)
   `RAAR_ASSERT_IMPLY(a_reset_idle, clock, reset, $past(reset), !rsp_valid)
endmodule

bind row_area_average_resampler raar_checker u_raar_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .pixel_out   (rsp_bus.pixel_out),
   .run_last    (rsp_bus.run_last),
   .ratio_error (rsp_bus.ratio_error)
);
`default_nettype wire
